[src/wpk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpk_pkg
// Shared types and constants for the nine-bit word packer.
// ----------------------------------------------------------------------------
package wpk_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_NOP_CODE        = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_FLAG_LEVEL = 1'd1;

  localparam logic [BYTE_W-1:0] NOP_CODE_RESET        = 8'h00;
  localparam logic              DATA_FLAG_LEVEL_RESET = 1'b1;

  localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_LAST  = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              is_command;
    logic              end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              group_end;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] nop_code;
    logic              data_flag_level;
  } cfg_t;

endpackage

[src/wpk_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpk_ctrl
// Item register and word sequencer: picks the next 9-bit word of the current
// transaction and forms one stream byte per cycle while emit_ready is high.
// ----------------------------------------------------------------------------
module wpk_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  wpk_pkg::cfg_t      cfg,
  input  logic               item_valid,
  output logic               item_stall,
  input  wpk_pkg::in_item_t  item,
  input  logic               emit_ready,
  output logic               emit_valid,
  output wpk_pkg::out_item_t emit
);
  import wpk_pkg::*;

  logic              busy;
  in_item_t          cur;
  logic              head_done;
  logic              aligned;
  logic              second;
  logic [BYTE_W-1:0] carry;
  logic [POS_W-1:0]  pos;

  logic              fire;
  logic              cmd_flag;
  logic              aligned_now;
  logic              pos_is_last;
  logic              word_flag;
  logic [BYTE_W-1:0] word_byte;
  logic              word_final;
  logic [BYTE_W:0]   word;
  logic              word_done;
  logic [15:0]       tail_wide;
  logic [BYTE_W-1:0] carry_next;
  logic [POS_W-1:0]  pos_next;
  logic              second_next;

  assign fire        = busy && emit_ready;
  assign cmd_flag    = ~cfg.data_flag_level;
  assign pos_is_last = (pos == POS_LAST);
  assign aligned_now = aligned || (pos == POS_FIRST);

  always_comb begin
    word_flag  = cmd_flag;
    word_byte  = cfg.nop_code;
    word_final = 1'b0;
    if (cur.is_command) begin
      if (aligned_now && pos_is_last) begin
        word_byte  = cur.byte_value;
        word_final = 1'b1;
      end
    end else if (!head_done) begin
      word_flag  = cfg.data_flag_level;
      word_byte  = cur.byte_value;
      word_final = !cur.end_of_block || pos_is_last;
    end else begin
      word_final = pos_is_last;
    end
  end

  assign word       = {word_flag, word_byte};
  assign word_done  = !pos_is_last || second;
  assign tail_wide  = {7'd0, word} << (POS_LAST - pos);

  always_comb begin
    emit.group_end = second;
    emit.last      = word_final && word_done;
    if (second) begin
      emit.packed_byte = word[BYTE_W-1:0];
    end else begin
      emit.packed_byte = carry | word[BYTE_W:1] >> pos;
    end
    if (!pos_is_last) begin
      carry_next  = tail_wide[BYTE_W-1:0];
      pos_next    = pos + 3'd1;
      second_next = 1'b0;
    end else if (second) begin
      carry_next  = '0;
      pos_next    = POS_FIRST;
      second_next = 1'b0;
    end else begin
      carry_next  = carry;
      pos_next    = pos;
      second_next = 1'b1;
    end
  end

  assign emit_valid = busy;
  assign item_stall = busy && !(fire && emit.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      carry     <= '0;
      pos       <= POS_FIRST;
      second    <= 1'b0;
      head_done <= 1'b0;
      aligned   <= 1'b0;
    end else begin
      if (fire) begin
        carry  <= carry_next;
        pos    <= pos_next;
        second <= second_next;
        if (word_done) begin
          head_done <= 1'b1;
          aligned   <= aligned_now;
        end
        if (emit.last) begin
          busy <= 1'b0;
        end
      end
      if (item_valid && !item_stall) begin
        busy      <= 1'b1;
        head_done <= 1'b0;
        aligned   <= 1'b0;
        second    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      cur <= item;
    end
  end

endmodule

[src/wpk_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpk_out_reg
// Result register: holds one stream byte until the receiver takes it.
// ----------------------------------------------------------------------------
module wpk_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               emit_valid,
  output logic               emit_ready,
  input  wpk_pkg::out_item_t emit,
  output logic               result_valid,
  input  logic               result_stall,
  output wpk_pkg::out_item_t result
);
  import wpk_pkg::*;

  assign emit_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_ready) begin
      result_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      result <= emit;
    end
  end

endmodule

[src/nine_bit_spi_word_packer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_bit_spi_word_packer_unit
// Packs display bytes into 9-bit data/command words, MSB first, as bytes.
//
// Input channel (item_valid / item_stall / item): one display byte per
// transaction with its command and end-of-block marks.
// Result channel (result_valid / result_stall / result): one packed byte per
// transaction; last marks the final byte of an input item, group_end the
// ninth byte of a group.
// Configuration: cfg_we writes cfg_data into register cfg_index (0: NOP
// code, 1: data flag level). Write only while the block is idle.
// Bytes become valid once they are stored in the result register. Throughput:
// one result byte per cycle while not stalled, set by the byte sequencer; an
// item causes 1 to 17 result bytes, and the next item is taken in the cycle
// its predecessor's last byte moves into the result register.
// Reset clears the bit carry and word position, sets the NOP code to 0 and
// the data flag level to 1. While result_stall is high the result holds and
// item_stall rises once the item register is occupied.
// ----------------------------------------------------------------------------
module nine_bit_spi_word_packer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wpk_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wpk_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  wpk_pkg::in_item_t                    item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output wpk_pkg::out_item_t                   result
);
  import wpk_pkg::*;

  cfg_t      cfg;
  logic      emit_valid;
  logic      emit_ready;
  out_item_t emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nop_code        <= NOP_CODE_RESET;
      cfg.data_flag_level <= DATA_FLAG_LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOP_CODE:        cfg.nop_code        <= cfg_data;
        REG_DATA_FLAG_LEVEL: cfg.data_flag_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wpk_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .emit_ready (emit_ready),
    .emit_valid (emit_valid),
    .emit       (emit)
  );

  wpk_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .emit_valid   (emit_valid),
    .emit_ready   (emit_ready),
    .emit         (emit),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[test/nine_bit_spi_word_packer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_bit_spi_word_packer_unit_tb
// Self-checking bench for the nine-bit word packer.
//
// A short table of directed transactions covers the field extremes, commands
// on open and closed groups, end of block on aligned and open groups, and
// both padding settings. Random data blocks with commands mixed in follow,
// under several register settings. Every packed byte is checked against a
// bit-level model of the word stream or against bytes listed in the table,
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module nine_bit_spi_word_packer_unit_tb;
  import wpk_pkg::*;

  typedef enum logic {STEP_ITEM, STEP_SETUP} step_kind_t;

  typedef struct packed {
    step_kind_t        kind;
    in_item_t          it;
    logic [BYTE_W-1:0] nop;
    logic              flag;
    logic [4:0]        n_bytes;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] fill;
    logic [BYTE_W-1:0] blast;
  } dir_row_t;

  localparam int N_DIR         = 28;
  localparam int N_PHASES      = 4;
  localparam int PHASE_ITEMS   = 19;
  localparam int WORDS_IN_GRP  = 8;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   item_valid;
  logic                   item_stall;
  in_item_t               item;
  logic                   result_valid;
  logic                   result_stall;
  out_item_t              result;

  logic [BYTE_W-1:0] nop_setting;
  logic              flag_setting;
  logic [BYTE_W-1:0] stream_carry;
  logic [POS_W-1:0]  stream_pos;

  out_item_t item_bytes[$];
  out_item_t expected_bytes[$];
  dir_row_t  dir_rows [N_DIR];

  bit quiet;
  int fail_count;
  int items_sent;
  int commands_sent;
  int eob_sent;
  int bytes_checked;
  int settings_used;

  nine_bit_spi_word_packer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Append one flag/byte word to the packed stream.
  function automatic void put_word(input logic flag, input logic [BYTE_W-1:0] b);
    int unsigned k;
    int unsigned pend;
    int unsigned t;
    int unsigned rest;
    out_item_t   o;
    k    = stream_pos;
    pend = stream_carry >> (8 - k);
    t    = (pend << 9) | {23'd0, flag, b};
    rest = t & ((32'd1 << (k + 1)) - 1);
    o    = '0;
    if (stream_pos == POS_LAST) begin
      o.packed_byte = 8'(t >> 8);
      item_bytes.push_back(o);
      o.packed_byte = 8'(rest);
      o.group_end   = 1'b1;
      item_bytes.push_back(o);
      stream_carry = '0;
      stream_pos   = POS_FIRST;
    end else begin
      o.packed_byte = 8'(t >> (k + 1));
      item_bytes.push_back(o);
      stream_carry = 8'(rest << (7 - k));
      stream_pos   = 3'(k + 1);
    end
  endfunction

  function automatic void pad_to_group();
    while (stream_pos != POS_FIRST) put_word(~flag_setting, nop_setting);
  endfunction

  function automatic void pack_item(input in_item_t it);
    out_item_t o;
    item_bytes.delete();
    if (it.is_command) begin
      pad_to_group();
      for (int i = 0; i < WORDS_IN_GRP - 1; i++) put_word(~flag_setting, nop_setting);
      put_word(~flag_setting, it.byte_value);
    end else begin
      put_word(flag_setting, it.byte_value);
      if (it.end_of_block) pad_to_group();
    end
    o = item_bytes.pop_back();
    o.last = 1'b1;
    item_bytes.push_back(o);
  endfunction

  function automatic dir_row_t data_row(input logic [7:0] b, input logic cmd,
                                        input logic eob);
    dir_row_t r;
    r = '0;
    r.kind            = STEP_ITEM;
    r.it.byte_value   = b;
    r.it.is_command   = cmd;
    r.it.end_of_block = eob;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic [7:0] b, input logic cmd,
                                         input logic eob, input int n,
                                         input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] fill, input logic [7:0] blast);
    dir_row_t r;
    r = data_row(b, cmd, eob);
    r.n_bytes = 5'(n);
    r.b0      = b0;
    r.b1      = b1;
    r.fill    = fill;
    r.blast   = blast;
    return r;
  endfunction

  function automatic dir_row_t setup_row(input logic [7:0] nop, input logic flag);
    dir_row_t r;
    r = '0;
    r.kind = STEP_SETUP;
    r.nop  = nop;
    r.flag = flag;
    return r;
  endfunction

  task automatic send_item(input dir_row_t row);
    int        gap;
    out_item_t o;
    gap = quiet ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= row.it;
    do @(posedge clk); while (item_stall !== 1'b0);
    pack_item(row.it);
    if (row.n_bytes != 0) begin
      item_bytes.delete();
      for (int i = 0; i < row.n_bytes; i++) begin
        o.packed_byte = (i == 0) ? row.b0 : (i == 1) ? row.b1 :
                        (i == row.n_bytes - 1) ? row.blast : row.fill;
        o.group_end   = (i == 8);
        o.last        = (i == row.n_bytes - 1);
        item_bytes.push_back(o);
      end
    end
    for (int i = 0; i < item_bytes.size(); i++) expected_bytes.push_back(item_bytes[i]);
    items_sent++;
    if (row.it.is_command) commands_sent++;
    else if (row.it.end_of_block) eob_sent++;
  endtask

  task automatic apply_setup(input logic [7:0] nop, input logic flag);
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NOP_CODE;
    cfg_data  <= nop;
    @(negedge clk);
    cfg_index <= REG_DATA_FLAG_LEVEL;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, flag};
    @(negedge clk);
    cfg_we <= 1'b0;
    nop_setting  = nop;
    flag_setting = flag;
    settings_used++;
  endtask

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_bytes.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected packed byte, expected none, actual %h", $time, result);
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (result.packed_byte !== want.packed_byte) begin
          fail_count++;
          $display("%0t: packed_byte expected %h actual %h", $time,
                   want.packed_byte, result.packed_byte);
        end
        if (result.group_end !== want.group_end) begin
          fail_count++;
          $display("%0t: group_end expected %b actual %b", $time,
                   want.group_end, result.group_end);
        end
        if (result.last !== want.last) begin
          fail_count++;
          $display("%0t: last expected %b actual %b", $time, want.last, result.last);
        end
      end
    end
  end

  initial begin : result_backpressure
    int hold;
    result_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 16);
      repeat (hold) begin
        @(negedge clk);
        result_stall <= 1'b1;
      end
      @(negedge clk);
      result_stall <= 1'b0;
      do @(posedge clk); while (result_valid !== 1'b1);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("%0t: run did not finish in time, %0d bytes still outstanding", $time,
             expected_bytes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    dir_row_t   row;
    int         r;
    logic [7:0] b;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    item_valid = 1'b0;
    item       = '0;
    quiet      = 1'b0;
    fail_count = 0;
    nop_setting  = NOP_CODE_RESET;
    flag_setting = DATA_FLAG_LEVEL_RESET;
    stream_carry = '0;
    stream_pos   = POS_FIRST;

    dir_rows[0]  = typed_row(8'h2C, 1'b1, 1'b0, 9, 8'h00, 8'h00, 8'h00, 8'h2C);
    dir_rows[1]  = typed_row(8'hA5, 1'b0, 1'b0, 1, 8'hD2, 8'h00, 8'h00, 8'h00);
    dir_rows[2]  = data_row(8'h00, 1'b0, 1'b1);
    dir_rows[3]  = typed_row(8'hFF, 1'b0, 1'b1, 9, 8'hFF, 8'h80, 8'h00, 8'h00);
    dir_rows[4]  = data_row(8'hFF, 1'b0, 1'b0);
    dir_rows[5]  = data_row(8'h00, 1'b0, 1'b0);
    dir_rows[6]  = data_row(8'h80, 1'b0, 1'b0);
    dir_rows[7]  = data_row(8'h01, 1'b0, 1'b0);
    dir_rows[8]  = data_row(8'h7F, 1'b0, 1'b0);
    dir_rows[9]  = data_row(8'hFE, 1'b0, 1'b0);
    dir_rows[10] = data_row(8'h55, 1'b0, 1'b0);
    dir_rows[11] = data_row(8'hAA, 1'b0, 1'b1);
    dir_rows[12] = typed_row(8'hC3, 1'b1, 1'b1, 9, 8'h00, 8'h00, 8'h00, 8'hC3);
    dir_rows[13] = data_row(8'h12, 1'b0, 1'b0);
    dir_rows[14] = data_row(8'h3A, 1'b1, 1'b0);
    dir_rows[15] = setup_row(8'hFF, 1'b0);
    dir_rows[16] = typed_row(8'h00, 1'b0, 1'b1, 9, 8'h00, 8'h7F, 8'hFF, 8'hFF);
    dir_rows[17] = typed_row(8'h00, 1'b1, 1'b0, 9, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    dir_rows[18] = data_row(8'h81, 1'b0, 1'b0);
    dir_rows[19] = data_row(8'h3C, 1'b0, 1'b0);
    dir_rows[20] = data_row(8'h0F, 1'b0, 1'b1);
    dir_rows[21] = data_row(8'hE7, 1'b0, 1'b0);
    dir_rows[22] = data_row(8'hFF, 1'b1, 1'b0);
    dir_rows[23] = setup_row(8'h55, 1'b1);
    dir_rows[24] = data_row(8'h00, 1'b0, 1'b1);
    dir_rows[25] = data_row(8'h80, 1'b1, 1'b1);
    dir_rows[26] = setup_row(8'h00, 1'b0);
    dir_rows[27] = data_row(8'h01, 1'b1, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      row = dir_rows[i];
      if (row.kind == STEP_SETUP) apply_setup(row.nop, row.flag);
      else send_item(row);
    end

    // random blocks of data, ended at random, with commands mixed in
    for (int p = 0; p < N_PHASES; p++) begin
      apply_setup(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      quiet = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        b = 8'($urandom_range(0, 255));
        if (r < 12) send_item(data_row(b, 1'b1, 1'($urandom_range(0, 1))));
        else send_item(data_row(b, 1'b0, r < 35));
      end
    end
    quiet = 1'b0;

    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions (%0d commands, %0d block ends) under %0d settings",
             items_sent, commands_sent, eob_sent, settings_used + 1);
    $display("Checked %0d packed bytes with random gaps and back-pressure", bytes_checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
src/wpk_pkg.sv
src/wpk_ctrl.sv
src/wpk_out_reg.sv
src/nine_bit_spi_word_packer_unit.sv
test/nine_bit_spi_word_packer_unit_tb.sv
